// ===== hdl/lcd_smt_pkg.sv =====
package lcd_smt_pkg;

  localparam int SPRITE_LIMIT_DEF = 10;

  // item actions
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // status mode codes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // timing constants
  localparam logic [8:0] LINE_DOTS       = 9'd456;
  localparam logic [9:0] TRANSFER_END    = 10'd252;
  localparam logic [8:0] OAM_DOTS        = 9'd80;
  localparam logic [7:0] LAST_LINE       = 8'd153;
  localparam logic [7:0] LAST_VISIBLE    = 8'd143;
  localparam logic [7:0] FIRST_VBLANK    = 8'd144;
  localparam int         DOTS_PER_SPRITE = 12;
  localparam logic [8:0] DOTS_ENABLE     = 9'd4;
  localparam logic [7:0] BIT7            = 8'h80;

  // register addresses
  localparam logic [15:0] ADDR_LCDC = 16'hFF40;
  localparam logic [15:0] ADDR_STAT = 16'hFF41;
  localparam logic [15:0] ADDR_SCY  = 16'hFF42;
  localparam logic [15:0] ADDR_SCX  = 16'hFF43;
  localparam logic [15:0] ADDR_LY   = 16'hFF44;
  localparam logic [15:0] ADDR_LYC  = 16'hFF45;
  localparam logic [15:0] ADDR_BGP  = 16'hFF47;
  localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
  localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
  localparam logic [15:0] ADDR_WY   = 16'hFF4A;
  localparam logic [15:0] ADDR_WX   = 16'hFF4B;
  localparam logic [15:0] ADDR_BCPS = 16'hFF68;
  localparam logic [15:0] ADDR_BCPD = 16'hFF69;
  localparam logic [15:0] ADDR_OCPS = 16'hFF6A;
  localparam logic [15:0] ADDR_OCPD = 16'hFF6B;

  // view register slots
  localparam int VIEW_SCY  = 0;
  localparam int VIEW_SCX  = 1;
  localparam int VIEW_BGP  = 2;
  localparam int VIEW_OBP0 = 3;
  localparam int VIEW_OBP1 = 4;
  localparam int VIEW_WY   = 5;
  localparam int VIEW_WX   = 6;
  localparam int VIEW_NUM  = 7;

  // color palette slots
  localparam int CPAL_BG_IDX  = 0;
  localparam int CPAL_BG_DAT  = 1;
  localparam int CPAL_OBJ_IDX = 2;
  localparam int CPAL_OBJ_DAT = 3;
  localparam int CPAL_NUM     = 4;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [5:0]  sprites_on_line;
  } lcd_smt_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       vblank_irq;
    logic       stat_irq;
  } lcd_smt_out_t;

endpackage

// ===== hdl/lcd_smt_in_stage.sv =====
module lcd_smt_in_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  lcd_smt_pkg::lcd_smt_in_t in_item,
  input  logic                     advance,
  output logic                     item_valid,
  output lcd_smt_pkg::lcd_smt_in_t item
);
  import lcd_smt_pkg::*;

  logic        held_valid_r;
  lcd_smt_in_t held_item_r;

  // stall only while the held item cannot move on this cycle
  assign in_stall   = held_valid_r && !advance;
  assign item_valid = held_valid_r;
  assign item       = held_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else if (!in_stall) begin
      held_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_item_r <= in_item;
    end
  end

endmodule

// ===== hdl/lcd_smt_core.sv =====
module lcd_smt_core #(
  parameter int SPRITE_LIMIT = lcd_smt_pkg::SPRITE_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  input  lcd_smt_pkg::lcd_smt_in_t  item,
  input  logic                      out_stall,
  output logic                      advance,
  output logic                      out_valid,
  output lcd_smt_pkg::lcd_smt_out_t out_item
);
  import lcd_smt_pkg::*;

  localparam int EXTRA_W = $clog2(DOTS_PER_SPRITE * SPRITE_LIMIT + 1);
  localparam logic [5:0] SPR_LIM = 6'(SPRITE_LIMIT);

  logic [7:0]         ctrl_r, ctrl_nxt;
  logic [7:0]         stat_r, stat_nxt;
  logic [7:0]         ly_r, ly_nxt;
  logic [7:0]         lyc_r, lyc_nxt;
  logic [8:0]         dc_r, dc_nxt;
  logic [EXTRA_W-1:0] extra_r, extra_nxt;
  logic               latch_r, latch_nxt;
  logic [7:0]         view_r [VIEW_NUM];
  logic [7:0]         view_nxt [VIEW_NUM];
  logic [7:0]         cpal_r [CPAL_NUM];
  logic [7:0]         cpal_nxt [CPAL_NUM];
  logic               out_valid_r;
  lcd_smt_out_t       out_item_r;

  lcd_smt_out_t       res;
  logic               fire;
  logic               raise;
  logic               coinc;
  logic [8:0]         dc_inc;
  logic [5:0]         spr_sat;
  logic [EXTRA_W-1:0] extra_calc;
  logic [EXTRA_W-1:0] xfer_extra;
  logic [9:0]         end3;

  assign advance   = !out_valid_r || !out_stall;
  assign fire      = item_valid && advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign dc_inc     = dc_r + 9'd1;
  assign coinc      = (lyc_r == ly_r);
  assign spr_sat    = (item.sprites_on_line > SPR_LIM) ? SPR_LIM : item.sprites_on_line;
  assign extra_calc = EXTRA_W'({4'd0, spr_sat} * 10'(DOTS_PER_SPRITE));
  assign end3       = TRANSFER_END + 10'(extra_r);

  always_comb begin
    ctrl_nxt   = ctrl_r;
    stat_nxt   = stat_r;
    ly_nxt     = ly_r;
    lyc_nxt    = lyc_r;
    dc_nxt     = dc_r;
    extra_nxt  = extra_r;
    latch_nxt  = latch_r;
    view_nxt   = view_r;
    cpal_nxt   = cpal_r;
    res        = '0;
    raise      = 1'b0;
    xfer_extra = extra_r;
    unique case (item.action)
      ACT_TICK: begin
        stat_nxt[2] = coinc;
        unique case (stat_r[1:0])
          MODE_OAM: begin
            if (dc_inc == 9'd1 && (stat_r[5] || (stat_r[6] && coinc))) raise = 1'b1;
            if (dc_inc == OAM_DOTS) stat_nxt[1:0] = MODE_XFER;
          end
          MODE_XFER: begin
            // sprite penalty is latched one dot into transfer
            if (dc_inc == OAM_DOTS + 9'd1 && ly_r <= LAST_VISIBLE) begin
              xfer_extra = ctrl_r[1] ? extra_calc : '0;
            end
            extra_nxt = xfer_extra;
            if ({1'b0, dc_inc} == TRANSFER_END + 10'(xfer_extra)) begin
              stat_nxt[1:0] = MODE_HBLANK;
            end
          end
          MODE_HBLANK: begin
            if ({1'b0, dc_inc} == end3 + 10'd1 && stat_r[3]) raise = 1'b1;
            if (dc_inc == LINE_DOTS) begin
              stat_nxt[1:0] = (ly_r == LAST_VISIBLE) ? MODE_VBLANK : MODE_OAM;
            end
          end
          MODE_VBLANK: begin
            if (ly_r == FIRST_VBLANK && dc_inc == 9'd1) begin
              res.vblank_irq = 1'b1;
              if (stat_r[4]) raise = 1'b1;
            end
          end
        endcase
        res.stat_irq = raise && !latch_r;
        if (dc_inc == LINE_DOTS) begin
          if (ly_r == LAST_LINE) begin
            stat_nxt[1:0] = MODE_OAM;
            ly_nxt        = '0;
          end else begin
            ly_nxt = ly_r + 8'd1;
          end
          dc_nxt    = '0;
          latch_nxt = 1'b0;
        end else begin
          dc_nxt    = dc_inc;
          latch_nxt = latch_r || raise;
        end
      end
      ACT_READ: begin
        unique case (item.address)
          ADDR_LCDC: res.read_data = ctrl_r;
          ADDR_STAT: res.read_data = BIT7 | stat_r;
          ADDR_SCY:  res.read_data = view_r[VIEW_SCY];
          ADDR_SCX:  res.read_data = view_r[VIEW_SCX];
          ADDR_LY:   res.read_data = ly_r;
          ADDR_LYC:  res.read_data = lyc_r;
          ADDR_BGP:  res.read_data = view_r[VIEW_BGP];
          ADDR_OBP0: res.read_data = view_r[VIEW_OBP0];
          ADDR_OBP1: res.read_data = view_r[VIEW_OBP1];
          ADDR_WY:   res.read_data = view_r[VIEW_WY];
          ADDR_WX:   res.read_data = view_r[VIEW_WX];
          ADDR_BCPS: res.read_data = cpal_r[CPAL_BG_IDX];
          ADDR_BCPD: res.read_data = cpal_r[CPAL_BG_DAT];
          ADDR_OCPS: res.read_data = cpal_r[CPAL_OBJ_IDX];
          ADDR_OCPD: res.read_data = cpal_r[CPAL_OBJ_DAT];
          default:   res.read_data = '0;
        endcase
      end
      ACT_WRITE: begin
        unique case (item.address)
          ADDR_LCDC: begin
            // enable toggle restarts the frame
            if (ctrl_r[7] != item.write_data[7]) begin
              dc_nxt        = item.write_data[7] ? DOTS_ENABLE : 9'd0;
              ly_nxt        = '0;
              stat_nxt[1:0] = MODE_OAM;
            end
            ctrl_nxt = item.write_data;
          end
          ADDR_STAT: stat_nxt = {item.write_data[7:3], stat_r[2:0]};
          ADDR_SCY:  view_nxt[VIEW_SCY] = item.write_data;
          ADDR_SCX:  view_nxt[VIEW_SCX] = item.write_data;
          ADDR_LY:   ly_nxt = '0;
          ADDR_LYC: begin
            lyc_nxt     = item.write_data;
            stat_nxt[2] = 1'b0;
          end
          ADDR_BGP:  view_nxt[VIEW_BGP] = item.write_data;
          ADDR_OBP0: view_nxt[VIEW_OBP0] = item.write_data;
          ADDR_OBP1: view_nxt[VIEW_OBP1] = item.write_data;
          ADDR_WY:   view_nxt[VIEW_WY] = item.write_data;
          ADDR_WX:   view_nxt[VIEW_WX] = item.write_data;
          ADDR_BCPS: cpal_nxt[CPAL_BG_IDX] = item.write_data;
          ADDR_BCPD: begin
            cpal_nxt[CPAL_BG_DAT] = item.write_data;
            if (cpal_r[CPAL_BG_IDX][7]) begin
              cpal_nxt[CPAL_BG_IDX][5:0] = cpal_r[CPAL_BG_IDX][5:0] + 6'd1;
            end
          end
          ADDR_OCPS: cpal_nxt[CPAL_OBJ_IDX] = item.write_data;
          ADDR_OCPD: begin
            cpal_nxt[CPAL_OBJ_DAT] = item.write_data;
            if (cpal_r[CPAL_OBJ_IDX][7]) begin
              cpal_nxt[CPAL_OBJ_IDX][5:0] = cpal_r[CPAL_OBJ_IDX][5:0] + 6'd1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      stat_r      <= {6'd0, MODE_OAM};
      ly_r        <= '0;
      lyc_r       <= '0;
      dc_r        <= '0;
      extra_r     <= '0;
      latch_r     <= 1'b0;
      view_r      <= '{default: '0};
      cpal_r      <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        ctrl_r  <= ctrl_nxt;
        stat_r  <= stat_nxt;
        ly_r    <= ly_nxt;
        lyc_r   <= lyc_nxt;
        dc_r    <= dc_nxt;
        extra_r <= extra_nxt;
        latch_r <= latch_nxt;
        view_r  <= view_nxt;
        cpal_r  <= cpal_nxt;
      end
      if (advance) begin
        out_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= res;
    end
  end

endmodule

// ===== hdl/lcd_scanline_mode_timer_unit.sv =====
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | in_item  (action, address, write_data, sprites)
// out_    | output    | out_valid/out_stall| out_item (read_data, vblank_irq, stat_irq)
//
// one item per clock sustained while out_stall stays low; each taken item is held in the input register
// and the whole tick, read or write is one pass of logic from there to the result register,
// so the core takes the next item whenever its result register is empty or being read out
// reset (rst_n low, synchronous) clears all timing and register state, mode starts in oam scan
// out_stall holds the result register; in_stall rises only while both stages are full and out_stall is high
module lcd_scanline_mode_timer_unit #(
  parameter int SPRITE_LIMIT = lcd_smt_pkg::SPRITE_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lcd_smt_pkg::lcd_smt_in_t  in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lcd_smt_pkg::lcd_smt_out_t out_item
);
  import lcd_smt_pkg::*;

  logic        advance;
  logic        item_valid;
  lcd_smt_in_t item;

  lcd_smt_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lcd_smt_core #(
    .SPRITE_LIMIT (SPRITE_LIMIT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_stall  (out_stall),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule

// ===== bench/lcd_scanline_mode_timer_unit_test.sv =====
`timescale 1ns / 100ps

module lcd_scanline_mode_timer_unit_test;
  import lcd_smt_pkg::*;

  // action code with no effect, not named in the package
  localparam logic [1:0] ACT_IDLE = 2'd3;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int TAIL_CYCLES = 12;
  localparam int RANDOM_ITEMS = 80;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  lcd_smt_in_t  in_item = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  lcd_smt_out_t out_item;

  lcd_scanline_mode_timer_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // shadow of the timer state
  logic [7:0] lcdc_shadow;
  logic [7:0] stat_shadow;
  logic [7:0] ly_shadow;
  logic [7:0] lyc_shadow;
  logic [8:0] dot_pos;
  int         sprite_dots;
  logic       line_irq_taken;
  logic [7:0] view_shadow [VIEW_NUM];
  logic [7:0] cpal_shadow [CPAL_NUM];

  lcd_smt_out_t expected_results [$];
  int fault_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_shadow();
    lcdc_shadow    = 8'd0;
    stat_shadow    = {6'd0, MODE_OAM};
    ly_shadow      = 8'd0;
    lyc_shadow     = 8'd0;
    dot_pos        = 9'd0;
    sprite_dots    = 0;
    line_irq_taken = 1'b0;
    for (int i = 0; i < VIEW_NUM; i++) view_shadow[i] = 8'd0;
    for (int i = 0; i < CPAL_NUM; i++) cpal_shadow[i] = 8'd0;
  endfunction

  // stat interrupt fires at most once per line
  function automatic logic claim_line_irq();
    if (line_irq_taken) return 1'b0;
    line_irq_taken = 1'b1;
    return 1'b1;
  endfunction

  function automatic lcd_smt_out_t advance_dot(input logic [5:0] sprites);
    lcd_smt_out_t res;
    int counted;
    res = '0;
    dot_pos = dot_pos + 9'd1;
    stat_shadow[2] = (lyc_shadow == ly_shadow);
    case (stat_shadow[1:0])
      MODE_OAM: begin
        if (dot_pos == 9'd1 && (stat_shadow[5] || (stat_shadow[6] && stat_shadow[2])))
          res.stat_irq = claim_line_irq();
        if (dot_pos == OAM_DOTS) stat_shadow[1:0] = MODE_XFER;
      end
      MODE_XFER: begin
        if (dot_pos == OAM_DOTS + 9'd1 && ly_shadow <= LAST_VISIBLE) begin
          counted = (int'(sprites) > SPRITE_LIMIT_DEF) ? SPRITE_LIMIT_DEF : int'(sprites);
          sprite_dots = lcdc_shadow[1] ? counted * DOTS_PER_SPRITE : 0;
        end
        if (int'(dot_pos) == int'(TRANSFER_END) + sprite_dots)
          stat_shadow[1:0] = MODE_HBLANK;
      end
      MODE_HBLANK: begin
        if (int'(dot_pos) == int'(TRANSFER_END) + sprite_dots + 1 && stat_shadow[3])
          res.stat_irq = claim_line_irq();
        if (dot_pos == LINE_DOTS)
          stat_shadow[1:0] = (ly_shadow == LAST_VISIBLE) ? MODE_VBLANK : MODE_OAM;
      end
      default: begin
        if (ly_shadow == FIRST_VBLANK && dot_pos == 9'd1) begin
          res.vblank_irq = 1'b1;
          if (stat_shadow[4]) res.stat_irq = claim_line_irq();
        end
      end
    endcase
    if (dot_pos == LINE_DOTS) begin
      if (ly_shadow == LAST_LINE) begin
        stat_shadow[1:0] = MODE_OAM;
        ly_shadow = 8'd0;
      end else begin
        ly_shadow = ly_shadow + 8'd1;
      end
      dot_pos = 9'd0;
      line_irq_taken = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [7:0] read_register(input logic [15:0] addr);
    case (addr)
      ADDR_LCDC: return lcdc_shadow;
      ADDR_STAT: return BIT7 | stat_shadow;
      ADDR_SCY:  return view_shadow[VIEW_SCY];
      ADDR_SCX:  return view_shadow[VIEW_SCX];
      ADDR_LY:   return ly_shadow;
      ADDR_LYC:  return lyc_shadow;
      ADDR_BGP:  return view_shadow[VIEW_BGP];
      ADDR_OBP0: return view_shadow[VIEW_OBP0];
      ADDR_OBP1: return view_shadow[VIEW_OBP1];
      ADDR_WY:   return view_shadow[VIEW_WY];
      ADDR_WX:   return view_shadow[VIEW_WX];
      ADDR_BCPS: return cpal_shadow[CPAL_BG_IDX];
      ADDR_BCPD: return cpal_shadow[CPAL_BG_DAT];
      ADDR_OCPS: return cpal_shadow[CPAL_OBJ_IDX];
      ADDR_OCPD: return cpal_shadow[CPAL_OBJ_DAT];
      default:   return 8'd0;
    endcase
  endfunction

  // data write steps the index when its auto-increment bit is set
  function automatic void write_palette_data(input int idx, input logic [7:0] data);
    logic [7:0] index;
    index = cpal_shadow[idx];
    cpal_shadow[idx + 1] = data;
    if (index[7]) cpal_shadow[idx] = {index[7:6], index[5:0] + 6'd1};
  endfunction

  function automatic void write_register(input logic [15:0] addr, input logic [7:0] data);
    case (addr)
      ADDR_LCDC: begin
        if (lcdc_shadow[7] != data[7]) begin
          dot_pos = data[7] ? DOTS_ENABLE : 9'd0;
          ly_shadow = 8'd0;
          stat_shadow[1:0] = MODE_OAM;
        end
        lcdc_shadow = data;
      end
      ADDR_STAT: stat_shadow = {data[7:3], stat_shadow[2:0]};
      ADDR_SCY:  view_shadow[VIEW_SCY] = data;
      ADDR_SCX:  view_shadow[VIEW_SCX] = data;
      ADDR_LY:   ly_shadow = 8'd0;
      ADDR_LYC: begin
        lyc_shadow = data;
        stat_shadow[2] = 1'b0;
      end
      ADDR_BGP:  view_shadow[VIEW_BGP] = data;
      ADDR_OBP0: view_shadow[VIEW_OBP0] = data;
      ADDR_OBP1: view_shadow[VIEW_OBP1] = data;
      ADDR_WY:   view_shadow[VIEW_WY] = data;
      ADDR_WX:   view_shadow[VIEW_WX] = data;
      ADDR_BCPS: cpal_shadow[CPAL_BG_IDX] = data;
      ADDR_BCPD: write_palette_data(CPAL_BG_IDX, data);
      ADDR_OCPS: cpal_shadow[CPAL_OBJ_IDX] = data;
      ADDR_OCPD: write_palette_data(CPAL_OBJ_IDX, data);
      default: ;
    endcase
  endfunction

  function automatic lcd_smt_out_t predict_result(input lcd_smt_in_t item);
    lcd_smt_out_t res;
    res = '0;
    case (item.action)
      ACT_TICK:  res = advance_dot(item.sprites_on_line);
      ACT_READ:  res.read_data = read_register(item.address);
      ACT_WRITE: write_register(item.address, item.write_data);
      default: ;
    endcase
    return res;
  endfunction

  function automatic lcd_smt_in_t make_item(input logic [1:0] action, input logic [15:0] addr,
                                            input logic [7:0] data, input logic [5:0] sprites);
    lcd_smt_in_t item;
    item.action = action;
    item.address = addr;
    item.write_data = data;
    item.sprites_on_line = sprites;
    return item;
  endfunction

  function automatic logic [15:0] pick_register();
    case ($urandom_range(14))
      0:  return ADDR_LCDC;
      1:  return ADDR_STAT;
      2:  return ADDR_SCY;
      3:  return ADDR_SCX;
      4:  return ADDR_LY;
      5:  return ADDR_LYC;
      6:  return ADDR_BGP;
      7:  return ADDR_OBP0;
      8:  return ADDR_OBP1;
      9:  return ADDR_WY;
      10: return ADDR_WX;
      11: return ADDR_BCPS;
      12: return ADDR_BCPD;
      13: return ADDR_OCPS;
      default: return ADDR_OCPD;
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(20, 6);
  endfunction

  task automatic report_fault(input string what, input int want, input int got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
  endtask

  task automatic send_item(input lcd_smt_in_t item);
    int gap;
    gap = pick_gap(idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_result(item));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_reset_values();
    send_item(make_item(ACT_READ, ADDR_STAT, 8'h00, 6'd0));
    send_item(make_item(ACT_IDLE, 16'hFFFF, 8'hFF, 6'h3F));
  endtask

  task automatic test_view_and_unlisted();
    send_item(make_item(ACT_WRITE, ADDR_SCX, 8'hFF, 6'd0));
    send_item(make_item(ACT_READ, ADDR_SCX, 8'h00, 6'd0));
    send_item(make_item(ACT_WRITE, 16'hFFFF, 8'hFF, 6'd0));
    send_item(make_item(ACT_READ, 16'hFFFF, 8'h00, 6'd0));
  endtask

  // stat write keeps the low bits, lyc write clears coincidence, ly write zeroes the line
  task automatic test_status_and_compare();
    send_item(make_item(ACT_WRITE, ADDR_STAT, 8'hFF, 6'd0));
    send_item(make_item(ACT_READ, ADDR_STAT, 8'h00, 6'd0));
    send_item(make_item(ACT_WRITE, ADDR_LYC, 8'h00, 6'd0));
    send_item(make_item(ACT_TICK, 16'h0000, 8'h00, 6'h3F));
    send_item(make_item(ACT_TICK, 16'h0000, 8'h00, 6'd0));
    send_item(make_item(ACT_WRITE, ADDR_LY, 8'hAB, 6'd0));
    send_item(make_item(ACT_READ, ADDR_LY, 8'h00, 6'd0));
  endtask

  task automatic test_control_restart();
    send_item(make_item(ACT_WRITE, ADDR_LCDC, 8'h80, 6'd0));
    send_item(make_item(ACT_READ, ADDR_LCDC, 8'h00, 6'd0));
    send_item(make_item(ACT_TICK, 16'h0000, 8'h00, 6'd0));
    send_item(make_item(ACT_WRITE, ADDR_LCDC, 8'h00, 6'd0));
    send_item(make_item(ACT_READ, ADDR_LY, 8'h00, 6'd0));
  endtask

  // index 0xbf wraps its low six bits and keeps the top two
  task automatic test_color_palette();
    send_item(make_item(ACT_WRITE, ADDR_BCPS, 8'hBF, 6'd0));
    send_item(make_item(ACT_WRITE, ADDR_BCPD, 8'h00, 6'd0));
    send_item(make_item(ACT_READ, ADDR_BCPS, 8'h00, 6'd0));
    send_item(make_item(ACT_WRITE, ADDR_OCPS, 8'h05, 6'd0));
    send_item(make_item(ACT_WRITE, ADDR_OCPD, 8'hFF, 6'd0));
    send_item(make_item(ACT_READ, ADDR_OCPS, 8'h00, 6'd0));
    send_item(make_item(ACT_READ, ADDR_OCPD, 8'h00, 6'd0));
  endtask

  // one whole line with all stat sources, from the enable restart through hblank
  // into the next oam scan
  task automatic test_full_frame();
    int dots;
    logic [5:0] sprites;
    idle_pct = 3;
    stall_pct = 3;
    send_item(make_item(ACT_WRITE, ADDR_LCDC, 8'h00, 6'd0));
    send_item(make_item(ACT_WRITE, ADDR_LCDC, 8'h82, 6'd0));
    send_item(make_item(ACT_WRITE, ADDR_STAT, 8'h78, 6'd0));
    send_item(make_item(ACT_WRITE, ADDR_LYC, 8'($urandom_range(153)), 6'd0));
    dots = int'(LINE_DOTS);
    for (int n = 0; n < dots; n++) begin
      sprites = ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12));
      send_item(make_item(ACT_TICK, 16'($urandom), 8'($urandom), sprites));
      if ($urandom_range(299) == 0) begin
        case ($urandom_range(3))
          0: send_item(make_item(ACT_READ, pick_register(), 8'd0, 6'd0));
          1: send_item(make_item(ACT_WRITE, ADDR_STAT, 8'($urandom), 6'd0));
          2: send_item(make_item(ACT_WRITE, ADDR_LYC, 8'($urandom_range(153)), 6'd0));
          default: send_item(make_item(ACT_WRITE, ADDR_LCDC, {1'b1, 7'($urandom)}, 6'd0));
        endcase
      end
    end
  endtask

  task automatic test_random_mix();
    int pick;
    logic [15:0] addr;
    logic [5:0] sprites;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        idle_pct = ($urandom_range(2) == 0) ? 0 : 35;
        stall_pct = ($urandom_range(2) == 0) ? 0 : 35;
      end
      // sender holds off until everything is back
      if (n == RANDOM_ITEMS / 2) drain_results();
      pick = $urandom_range(99);
      addr = ($urandom_range(99) < 85) ? pick_register() : 16'($urandom);
      sprites = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(15));
      if (pick < 62)
        send_item(make_item(ACT_TICK, 16'($urandom), 8'($urandom), sprites));
      else if (pick < 80)
        send_item(make_item(ACT_READ, addr, 8'($urandom), sprites));
      else if (pick < 97)
        send_item(make_item(ACT_WRITE, addr, 8'($urandom), sprites));
      else
        send_item(make_item(ACT_IDLE, 16'($urandom), 8'($urandom), sprites));
    end
  endtask

  initial begin : receiver_stall
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        hold = pick_gap(stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    lcd_smt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_fault("unexpected item", 0, int'(out_item));
      end else begin
        want = expected_results.pop_front();
        if (want.read_data != out_item.read_data)
          report_fault("read_data", int'(want.read_data), int'(out_item.read_data));
        if (want.vblank_irq != out_item.vblank_irq)
          report_fault("vblank_irq", int'(want.vblank_irq), int'(out_item.vblank_irq));
        if (want.stat_irq != out_item.stat_irq)
          report_fault("stat_irq", int'(want.stat_irq), int'(out_item.stat_irq));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[lcd_scanline_mode_timer_unit] ERROR");
    $finish;
  end

  initial begin
    clear_shadow();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_values();
    test_view_and_unlisted();
    test_status_and_compare();
    test_control_restart();
    test_color_palette();
    test_full_frame();
    test_random_mix();
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_results.size() != 0)
      report_fault("missing items", expected_results.size(), 0);
    if (fault_count == 0)
      $display("[lcd_scanline_mode_timer_unit] OK");
    else
      $display("[lcd_scanline_mode_timer_unit] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lcd_smt_pkg.sv
hdl/lcd_smt_in_stage.sv
hdl/lcd_smt_core.sv
hdl/lcd_scanline_mode_timer_unit.sv
bench/lcd_scanline_mode_timer_unit_test.sv
